FILE: hw/rtl/sder_pkg.sv
// Shared constants and control types for the DER signature encoder.
`default_nettype none
package sder_pkg;

  localparam int unsigned COMPONENT_BYTES = 32;
  localparam int unsigned SIG_BYTES       = 2 * COMPONENT_BYTES;
  localparam int unsigned ADDR_W          = $clog2(SIG_BYTES);
  localparam int unsigned CNT_W           = $clog2(SIG_BYTES + 1);
  localparam int unsigned LZ_W            = $clog2(COMPONENT_BYTES + 1);
  // longest encoding: 5 header bytes plus two padded INTEGERs
  localparam int unsigned POS_W           = $clog2(2 * COMPONENT_BYTES + 12);

  localparam logic [7:0] TAG_INTEGER    = 8'h02;
  localparam logic [7:0] TAG_BIT_STRING = 8'h03;
  localparam logic [7:0] TAG_SEQUENCE   = 8'h30;
  localparam logic [7:0] BYTE_ZERO      = 8'h00;

  typedef struct packed {
    logic load;   // store one signature byte
    logic start;  // begin emitting the encoding
  } sder_cmd_t;

  typedef struct packed {
    logic last_byte;  // next byte completes the signature
    logic emit_done;  // final word handed to the output register
  } sder_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sder_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sder_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sder_ctrl.sv
// Controller: load phase and emit phase sequencing.
`default_nettype none
module sder_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  sig_valid_i,
  output logic                       sig_stall_o,
  input  wire sder_pkg::sder_status_t status_i,
  output sder_pkg::sder_cmd_t        cmd_o
);
  import sder_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e state_q, state_d;

  assign sig_stall_o = (state_q != ST_LOAD);
  assign cmd_o.load  = sig_valid_i && (state_q == ST_LOAD);
  assign cmd_o.start = cmd_o.load && status_i.last_byte;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (cmd_o.start) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.emit_done) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sder_dp.sv
// Datapath: signature store, leading-zero tracking, byte sequencer and word packer.
`default_nettype none
module sder_dp (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire sder_pkg::sder_cmd_t    cmd_i,
  output sder_pkg::sder_status_t      status_o,
  input  wire logic [7:0]             sig_byte_i,
  output logic      [63:0]            der_word_o,
  output logic      [3:0]             byte_count_o,
  output logic                        last_word_o,
  output logic                        der_valid_o,
  input  wire logic                   der_stall_i
);
  import sder_pkg::*;

  // load side
  logic [CNT_W-1:0]  loaded_q, loaded_d;
  logic [LZ_W-1:0]   rlz_q, rlz_d, slz_q, slz_d;
  logic              rpad_q, rpad_d, spad_q, spad_d;
  logic              in_r;
  logic [CNT_W-1:0]  s_idx;

  // emit side
  logic              emitting_q, emitting_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_ram_q;
  logic [7:0]        s1_const_q;
  logic              s1_last_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [2:0]        lane_q, lane_d;
  logic [63:0]       pack_q, pack_d;
  logic              out_valid_q, out_valid_d;
  logic [63:0]       out_word_q;
  logic [3:0]        out_cnt_q;
  logic              out_last_q;

  logic [POS_W-1:0]  rint, sint, rlen, slen, seq, s_start, total;
  logic              p_ram, p_last;
  logic [7:0]        p_const;
  logic [ADDR_W-1:0] p_addr, raddr;
  logic [7:0]        ram_rdata, cur_byte;
  logic              out_free, word_full, adv, push;
  logic [63:0]       merged;

  sder_ram #(
    .WIDTH(8),
    .DEPTH(SIG_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load),
    .waddr_i(loaded_q[ADDR_W-1:0]),
    .wdata_i(sig_byte_i),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // leading zero count and pad flag, tracked as bytes arrive
  assign in_r  = (loaded_q < CNT_W'(COMPONENT_BYTES));
  assign s_idx = loaded_q - CNT_W'(COMPONENT_BYTES);

  always_comb begin
    loaded_d = loaded_q;
    rlz_d    = rlz_q;
    slz_d    = slz_q;
    rpad_d   = rpad_q;
    spad_d   = spad_q;
    if (cmd_i.load) begin
      loaded_d = cmd_i.start ? '0 : loaded_q + CNT_W'(1);
      if (in_r) begin
        if (CNT_W'(rlz_q) == loaded_q) begin
          if (sig_byte_i == BYTE_ZERO) rlz_d = rlz_q + LZ_W'(1);
          else rpad_d = sig_byte_i[7];
        end
      end else begin
        if (CNT_W'(slz_q) == s_idx) begin
          if (sig_byte_i == BYTE_ZERO) slz_d = slz_q + LZ_W'(1);
          else spad_d = sig_byte_i[7];
        end
      end
    end
    if (status_o.emit_done) begin
      rlz_d  = '0;
      slz_d  = '0;
      rpad_d = 1'b0;
      spad_d = 1'b0;
    end
  end

  assign status_o.last_byte = (loaded_q == CNT_W'(SIG_BYTES - 1));

  // lengths of the encoding
  assign rint    = POS_W'(COMPONENT_BYTES) - POS_W'(rlz_q) + POS_W'(rpad_q);
  assign sint    = POS_W'(COMPONENT_BYTES) - POS_W'(slz_q) + POS_W'(spad_q);
  assign rlen    = rint + POS_W'(2);
  assign slen    = sint + POS_W'(2);
  assign seq     = rlen + slen;
  assign s_start = rlen + POS_W'(5);
  assign total   = seq + POS_W'(5);

  // source of the byte at stream position pos_q
  always_comb begin
    p_ram   = 1'b0;
    p_const = BYTE_ZERO;
    p_addr  = '0;
    p_last  = (pos_q == total - POS_W'(1));
    if (pos_q == POS_W'(0)) begin
      p_const = TAG_BIT_STRING;
    end else if (pos_q == POS_W'(1)) begin
      p_const = 8'(seq + POS_W'(3));
    end else if (pos_q == POS_W'(2)) begin
      p_const = BYTE_ZERO;
    end else if (pos_q == POS_W'(3)) begin
      p_const = TAG_SEQUENCE;
    end else if (pos_q == POS_W'(4)) begin
      p_const = 8'(seq);
    end else if (pos_q == POS_W'(5)) begin
      p_const = TAG_INTEGER;
    end else if (pos_q == POS_W'(6)) begin
      p_const = 8'(rint);
    end else if (rpad_q && pos_q == POS_W'(7)) begin
      p_const = BYTE_ZERO;
    end else if (pos_q < s_start) begin
      p_ram  = 1'b1;
      p_addr = ADDR_W'(POS_W'(rlz_q) + pos_q - POS_W'(7) - POS_W'(rpad_q));
    end else if (pos_q == s_start) begin
      p_const = TAG_INTEGER;
    end else if (pos_q == s_start + POS_W'(1)) begin
      p_const = 8'(sint);
    end else if (spad_q && pos_q == s_start + POS_W'(2)) begin
      p_const = BYTE_ZERO;
    end else begin
      p_ram  = 1'b1;
      p_addr = ADDR_W'(POS_W'(COMPONENT_BYTES) + POS_W'(slz_q) + pos_q - s_start
                       - POS_W'(2) - POS_W'(spad_q));
    end
  end

  // hold the pipeline while a finished word cannot leave
  assign out_free  = !out_valid_q || !der_stall_i;
  assign word_full = (lane_q == 3'd7) || s1_last_q;
  assign adv       = !(s1_valid_q && word_full && !out_free);
  assign push      = adv && s1_valid_q && word_full;
  assign status_o.emit_done = push && s1_last_q;

  // on a hold, re-read the address already in flight
  assign raddr    = adv ? p_addr : s1_addr_q;
  assign cur_byte = s1_ram_q ? ram_rdata : s1_const_q;

  always_comb begin
    merged = pack_q;
    merged[lane_q*8 +: 8] = cur_byte;
  end

  always_comb begin
    emitting_d  = emitting_q;
    pos_d       = pos_q;
    s1_valid_d  = s1_valid_q;
    lane_d      = lane_q;
    pack_d      = pack_q;
    out_valid_d = out_valid_q && der_stall_i;
    if (cmd_i.start) begin
      emitting_d = 1'b1;
      pos_d      = '0;
    end else if (adv) begin
      s1_valid_d = emitting_q;
      if (emitting_q) begin
        pos_d = pos_q + POS_W'(1);
        if (p_last) emitting_d = 1'b0;
      end
    end
    if (adv && s1_valid_q) begin
      if (word_full) begin
        lane_d      = '0;
        pack_d      = '0;
        out_valid_d = 1'b1;
      end else begin
        lane_d = lane_q + 3'd1;
        pack_d = merged;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      rlz_q       <= '0;
      slz_q       <= '0;
      rpad_q      <= 1'b0;
      spad_q      <= 1'b0;
      emitting_q  <= 1'b0;
      pos_q       <= '0;
      s1_valid_q  <= 1'b0;
      lane_q      <= '0;
      pack_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      loaded_q    <= loaded_d;
      rlz_q       <= rlz_d;
      slz_q       <= slz_d;
      rpad_q      <= rpad_d;
      spad_q      <= spad_d;
      emitting_q  <= emitting_d;
      pos_q       <= pos_d;
      s1_valid_q  <= s1_valid_d;
      lane_q      <= lane_d;
      pack_q      <= pack_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ram_q   <= p_ram;
      s1_const_q <= p_const;
      s1_last_q  <= p_last;
      s1_addr_q  <= p_addr;
    end
    if (push) begin
      out_word_q <= merged;
      out_cnt_q  <= {1'b0, lane_q} + 4'd1;
      out_last_q <= s1_last_q;
    end
  end

  assign der_word_o   = out_word_q;
  assign byte_count_o = out_cnt_q;
  assign last_word_o  = out_last_q;
  assign der_valid_o  = out_valid_q;

endmodule
`default_nettype wire

FILE: hw/rtl/ecdsa_signature_der_encoder_unit.sv
// ECDSA raw signature to DER encoder, top level.
//
// Input channel: sig_byte_i with sig_valid_i / sig_stall_o, one raw byte per
// transaction, r then s, most significant first, 64 bytes per signature.
// Output channel: der_word_o (first byte in bits 7:0), byte_count_o and
// last_word_o with der_valid_o / der_stall_i, one 8-byte word per transaction.
// Bytes load at one per cycle into the signature RAM. After the last byte the
// input stalls while the sequencer walks the DER stream one byte per cycle
// unless the output stalls; an encoding is at most 75 bytes. Each byte passes
// from the position counter through the stage-1 register into the word packer,
// and a full word then moves to the output register.
// The final word sits in the output register while the next signature loads.
// A stall on the output holds the byte sequencer; nothing is dropped.
// Reset clears the controller, counters and output valid; RAM contents are not
// cleared and need not be, since every byte read was written first.
`default_nettype none
module ecdsa_signature_der_encoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  sig_byte_i,
  input  wire logic        sig_valid_i,
  output logic             sig_stall_o,
  output logic      [63:0] der_word_o,
  output logic      [3:0]  byte_count_o,
  output logic             last_word_o,
  output logic             der_valid_o,
  input  wire logic        der_stall_i
);
  import sder_pkg::*;

  sder_cmd_t    cmd;
  sder_status_t status;

  sder_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sig_valid_i(sig_valid_i),
    .sig_stall_o(sig_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sder_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sig_byte_i  (sig_byte_i),
    .der_word_o  (der_word_o),
    .byte_count_o(byte_count_o),
    .last_word_o (last_word_o),
    .der_valid_o (der_valid_o),
    .der_stall_i (der_stall_i)
  );

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    der_valid_o |-> (byte_count_o != 4'd0) && (byte_count_o <= 4'd8))
    else $error("output byte count out of range");

  a_start_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> sig_stall_o)
    else $error("input not stalled after last signature byte");

  a_done_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.emit_done |=> !sig_stall_o && der_valid_o && last_word_o)
    else $error("emission end did not reopen input with last word pending");

  a_partial_word_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    der_valid_o && (byte_count_o != 4'd8) |-> last_word_o)
    else $error("short word that is not the final word");

endmodule
`default_nettype wire
